[src/ate_pkg.sv]
// ----------------------------------------------------------------------------
// Treble exciter package
// Shared widths, register indexes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package ate_pkg;

    localparam int SampleW = 32;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] RegB0B2    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegB1      = 3'd1;
    localparam logic [CfgIdxW-1:0] RegA1      = 3'd2;
    localparam logic [CfgIdxW-1:0] RegA2      = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDcPole  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegGain    = 3'd5;
    localparam logic [CfgIdxW-1:0] RegFracBit = 3'd6;
    localparam logic [CfgIdxW-1:0] RegStereo  = 3'd7;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,      // latch channel input as filter input
        OP_CLR,       // clear accumulator
        OP_MAC,       // accumulate product of selected tap
        OP_BQ_END,    // take biquad result, update that filter's history
        OP_RECT,      // rectify filter output, form dc product
        OP_DC_END,    // finish dc blocker, clamp, update state
        OP_GAIN,      // multiply filter output by gain
        OP_MIX,       // add to dry sample, clamp, store channel result
        OP_MONO,      // copy left result into right
        OP_OUT        // move both channel results into the output register
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       ch;      // channel
        logic [1:0] filt;    // filter number 0..2
        logic [2:0] tap;     // 0 x, 1 x1, 2 x2, 3 y1, 4 y2
    } t_cmd;

endpackage

[src/audio_treble_exciter.sv]
// ----------------------------------------------------------------------------
// Treble harmonic exciter
// Channel        | Direction | Contents
// s_axis         | in        | tdata: left_in[31:0], right_in[63:32]
// m_axis         | out       | tdata: left_out[31:0], right_out[63:32]
// cfg            | in        | register index 0..7 and 32-bit write data
// Each channel runs on the single shared multiplier: a load, two biquads of
// clear, five taps and commit, the DC blocker, a third biquad, then gain and
// mix. The DC blocker and the gain step each hold their product in a wait state.
// Reset is synchronous; it clears the filter state and sets the configuration to its defaults.
// A finished result waits in the output register while the next request is
// processed; that request stalls in its output step until the result is taken.
// ----------------------------------------------------------------------------
module audio_treble_exciter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // left_in[31:0], right_in[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // left_out[31:0], right_out[63:32]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic signed [31:0] r_b0b2, r_b1, r_a1, r_a2;
    logic        [24:0] r_dc_pole;
    logic        [30:0] r_gain;
    logic        [4:0]  r_frac;
    logic               r_stereo;
    logic signed [31:0] r_in_l, r_in_r;
    ate_pkg::t_cmd      w_cmd;
    logic signed [31:0] w_left, w_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0b2 <= '0; r_b1 <= '0; r_a1 <= '0; r_a2 <= '0;
            r_dc_pole <= 25'h1000000; r_gain <= '0; r_frac <= 5'd27; r_stereo <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ate_pkg::RegB0B2:    r_b0b2    <= i_cfg_data;
                ate_pkg::RegB1:      r_b1      <= i_cfg_data;
                ate_pkg::RegA1:      r_a1      <= i_cfg_data;
                ate_pkg::RegA2:      r_a2      <= i_cfg_data;
                ate_pkg::RegDcPole:  r_dc_pole <= i_cfg_data[24:0];
                ate_pkg::RegGain:    r_gain    <= i_cfg_data[30:0];
                ate_pkg::RegFracBit: r_frac    <= i_cfg_data[4:0];
                ate_pkg::RegStereo:  r_stereo  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_l <= s_axis_tdata[31:0];
            r_in_r <= s_axis_tdata[63:32];
        end
    end

    ate_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stereo    (r_stereo),
        .o_cmd       (w_cmd)
    );

    ate_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd       (w_cmd),
        .i_left      (r_in_l),
        .i_right     (r_in_r),
        .i_b0b2      (r_b0b2),
        .i_b1        (r_b1),
        .i_a1        (r_a1),
        .i_a2        (r_a2),
        .i_dc_pole   (r_dc_pole),
        .i_gain      (r_gain),
        .i_fs_bits   (r_frac),
        .o_left      (w_left),
        .o_right     (w_right)
    );

    assign m_axis_tdata = {w_right, w_left};

endmodule

[src/ate_datapath.sv]
// ----------------------------------------------------------------------------
// Treble exciter datapath
// One shared 33x33 signed multiplier feeding a 64-bit accumulator and a
// registered product, plus filter histories, DC blocker state and result registers.
// ----------------------------------------------------------------------------
module ate_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ate_pkg::t_cmd              i_cmd,
    input  logic signed [31:0]         i_left,
    input  logic signed [31:0]         i_right,
    input  logic signed [31:0]         i_b0b2,
    input  logic signed [31:0]         i_b1,
    input  logic signed [31:0]         i_a1,
    input  logic signed [31:0]         i_a2,
    input  logic        [24:0]         i_dc_pole,
    input  logic        [30:0]         i_gain,
    input  logic        [4:0]          i_fs_bits,
    output logic signed [31:0]         o_left,
    output logic signed [31:0]         o_right
);

    // History index: filter*2+channel, entries x1,x2,y1,y2.
    logic signed [31:0] r_hist [6][4];
    logic signed [31:0] r_dcy  [2];
    logic signed [32:0] r_last [2];   // 0 .. 2^31
    logic signed [31:0] r_x;          // current filter input
    logic signed [31:0] r_y;          // last filter output
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;       // registered product
    logic signed [32:0] r_rect;
    logic signed [31:0] r_left, r_right;
    logic signed [31:0] r_out_l, r_out_r;

    logic [2:0]          w_hidx;
    logic signed [32:0]  w_ma, w_mb;
    logic signed [65:0]  w_mul;
    logic signed [31:0]  w_in_ch, w_ybq, w_xin;
    logic signed [33:0]  w_full;
    logic signed [33:0]  w_bound;
    logic signed [65:0]  w_hp;
    logic signed [65:0]  w_r;
    logic signed [63:0]  w_dcsh, w_harm;

    assign w_hidx  = {i_cmd.filt, i_cmd.ch};
    assign w_in_ch = i_cmd.ch ? i_right : i_left;
    assign w_ybq   = r_acc[55:24];
    // The first filter sees the dry sample, the second the first one's output
    // and the third the DC blocker output.
    assign w_xin   = (i_cmd.filt == 2'd0) ? r_x :
                     (i_cmd.filt == 2'd1) ? r_y : r_dcy[i_cmd.ch];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            ate_pkg::OP_MAC: begin
                unique case (i_cmd.tap)
                    3'd0:    begin w_ma = 33'(w_xin); w_mb = 33'(i_b0b2); end
                    3'd1:    begin w_ma = 33'(r_hist[w_hidx][0]); w_mb = 33'(i_b1); end
                    3'd2:    begin w_ma = 33'(r_hist[w_hidx][1]); w_mb = 33'(i_b0b2); end
                    3'd3:    begin w_ma = 33'(r_hist[w_hidx][2]); w_mb = 33'(i_a1); end
                    3'd4:    begin w_ma = 33'(r_hist[w_hidx][3]); w_mb = 33'(i_a2); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            ate_pkg::OP_RECT: begin
                w_ma = 33'(r_dcy[i_cmd.ch]);
                w_mb = {8'd0, i_dc_pole};
            end
            ate_pkg::OP_GAIN: begin
                w_ma = 33'(r_y);
                w_mb = {2'd0, i_gain};
            end
            default: ;
        endcase
    end
    assign w_mul = w_ma * w_mb;

    always_comb begin
        w_full  = (34'sd1 <<< i_fs_bits) - 34'sd1;
        w_bound = (w_full <<< 1) > 34'sd2147483647 ? 34'sd2147483647 : (w_full <<< 1);
        w_dcsh  = r_prod >>> 24;
        w_hp    = 66'(r_rect) - 66'(r_last[i_cmd.ch]) + 66'(w_dcsh);
        w_harm  = r_prod >>> 24;
        w_r     = 66'(r_x) + 66'(w_harm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++)
                for (int k = 0; k < 4; k++)
                    r_hist[i][k] <= '0;
            r_dcy[0]  <= '0;
            r_dcy[1]  <= '0;
            r_last[0] <= '0;
            r_last[1] <= '0;
        end else begin
            // The product is held through the wait cycle that follows it.
            if (i_cmd.op == ate_pkg::OP_RECT || i_cmd.op == ate_pkg::OP_GAIN)
                r_prod <= w_mul[63:0];
            unique case (i_cmd.op)
                ate_pkg::OP_LOAD: r_x <= w_in_ch;
                ate_pkg::OP_CLR:  r_acc <= '0;
                ate_pkg::OP_MAC:  r_acc <= r_acc + w_mul[63:0];
                ate_pkg::OP_BQ_END: begin
                    // Commits the accumulator that holds the last tap's product.
                    r_y <= w_ybq;
                    r_hist[w_hidx][1] <= r_hist[w_hidx][0];
                    r_hist[w_hidx][0] <= w_xin;
                    r_hist[w_hidx][3] <= r_hist[w_hidx][2];
                    r_hist[w_hidx][2] <= w_ybq;
                end
                ate_pkg::OP_RECT: r_rect <= r_y[31] ? -33'(r_y) : 33'(r_y);
                ate_pkg::OP_DC_END: begin
                    r_last[i_cmd.ch] <= r_rect;
                    if (w_hp > 66'(w_bound))       r_dcy[i_cmd.ch] <= w_bound[31:0];
                    else if (w_hp < -66'(w_bound)) r_dcy[i_cmd.ch] <= 32'(-w_bound);
                    else                           r_dcy[i_cmd.ch] <= w_hp[31:0];
                end
                ate_pkg::OP_MIX: begin
                    logic signed [31:0] v;
                    if (w_r > 66'(w_full))       v = w_full[31:0];
                    else if (w_r < -66'(w_full)) v = 32'(-w_full);
                    else                         v = w_r[31:0];
                    if (i_cmd.ch) r_right <= v;
                    else          r_left  <= v;
                end
                ate_pkg::OP_MONO: r_right <= r_left;
                ate_pkg::OP_OUT: begin
                    r_out_l <= r_left;
                    r_out_r <= r_right;
                end
                default: ;
            endcase
        end
    end

    assign o_left  = r_out_l;
    assign o_right = r_out_r;

endmodule

[src/ate_ctrl.sv]
// ----------------------------------------------------------------------------
// Treble exciter controller
// Sequences the datapath through one or both channels and the output handshake.
// ----------------------------------------------------------------------------
module ate_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          i_stereo,
    output ate_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CLR, S_MAC, S_BQEND, S_RECT, S_RWAIT, S_DCEND,
        S_GAIN, S_GWAIT, S_MIX, S_MONO, S_OUT
    } t_state;

    t_state      r_state;
    logic        r_ch;
    logic [1:0]  r_filt;
    logic [2:0]  r_tap;
    logic        r_out_valid;
    logic        w_out_go;

    // A new request is taken only while idle; its samples are registered at
    // the top level and stay put until the next request.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // The output register is free when empty or being read this cycle.
    assign w_out_go    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '{op: ate_pkg::OP_NOP, ch: r_ch, filt: r_filt, tap: r_tap};
        unique case (r_state)
            S_LOAD:  o_cmd.op = ate_pkg::OP_LOAD;
            S_CLR:   o_cmd.op = ate_pkg::OP_CLR;
            S_MAC:   o_cmd.op = ate_pkg::OP_MAC;
            S_BQEND: o_cmd.op = ate_pkg::OP_BQ_END;
            S_RECT:  o_cmd.op = ate_pkg::OP_RECT;
            S_DCEND: o_cmd.op = ate_pkg::OP_DC_END;
            S_GAIN:  o_cmd.op = ate_pkg::OP_GAIN;
            S_MIX:   o_cmd.op = ate_pkg::OP_MIX;
            S_MONO:  o_cmd.op = ate_pkg::OP_MONO;
            S_OUT:   o_cmd.op = w_out_go ? ate_pkg::OP_OUT : ate_pkg::OP_NOP;
            default: o_cmd.op = ate_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ch <= 1'b0; r_filt <= '0; r_tap <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_go) r_out_valid <= 1'b1;
            else if (i_out_ready)            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state <= S_LOAD; r_ch <= 1'b0;
                end
                S_LOAD: begin r_state <= S_CLR; r_filt <= 2'd0; end
                S_CLR:  begin r_state <= S_MAC; r_tap <= 3'd0; end
                // The accumulator adds the product of the same cycle.
                S_MAC: if (r_tap == 3'd4) r_state <= S_BQEND;
                       else r_tap <= r_tap + 3'd1;
                S_BQEND: begin
                    if (r_filt == 2'd0)      begin r_filt <= 2'd1; r_state <= S_CLR; end
                    else if (r_filt == 2'd1) r_state <= S_RECT;
                    else                     r_state <= S_GAIN;
                end
                S_RECT:  r_state <= S_RWAIT;
                S_RWAIT: r_state <= S_DCEND;
                S_DCEND: begin r_filt <= 2'd2; r_state <= S_CLR; end
                S_GAIN:  r_state <= S_GWAIT;
                S_GWAIT: r_state <= S_MIX;
                S_MIX: begin
                    if (!r_ch && i_stereo) begin r_ch <= 1'b1; r_state <= S_LOAD; end
                    else if (!r_ch)        r_state <= S_MONO;
                    else                   r_state <= S_OUT;
                end
                S_MONO: r_state <= S_OUT;
                S_OUT: if (w_out_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/ate_checker.sv]
// ----------------------------------------------------------------------------
// Treble exciter port checker
// Watches the stream ports of the top level for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module ate_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second frame taken while busy");

    a_no_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result shown without processing");

    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("not ready for a request after finishing a result");

endmodule

bind audio_treble_exciter ate_checker u_ate_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[tb/audio_treble_exciter_tb.sv]
// ----------------------------------------------------------------------------
// Treble exciter testbench
// Drives stereo frames through the exciter and checks every output frame.
// The expected frames come from an internal model of the filter chain:
// two high-pass biquads, a rectifier, a DC blocker, a third biquad, then
// gain, mix and clamp.
// The register settings cover typical high-pass filters, full-range
// coefficients, mono mode and the extremes of the pole, the gain and the
// fraction width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_treble_exciter_tb;

    localparam int CycleLimit = 3000000;
    localparam int DrainCycles = 240;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // left_in[31:0], right_in[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // left_out[31:0], right_out[63:32]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    audio_treble_exciter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Model registers and per-channel filter state.
    longint    cb0, cb1, ca1, ca2, pole, gain;
    int        fs_bits;
    bit        stereo;
    int        hist [3][2][4];
    longint    dc_out [2];
    longint    last_rect [2];

    logic [63:0] exp_frames [$];
    int          errors = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    longint      cycles = 0;

    function automatic int run_biquad(int f, int ch, int x);
        longint acc;
        int     y;
        acc = longint'(x) * cb0 + longint'(hist[f][ch][0]) * cb1
            + longint'(hist[f][ch][1]) * cb0 + longint'(hist[f][ch][2]) * ca1
            + longint'(hist[f][ch][3]) * ca2;
        y = int'(acc[55:24]);
        hist[f][ch][1] = hist[f][ch][0];
        hist[f][ch][0] = x;
        hist[f][ch][3] = hist[f][ch][2];
        hist[f][ch][2] = y;
        return y;
    endfunction

    function automatic longint excite_channel(int ch, int x, longint full, longint bound);
        int     hf;
        int     hh;
        longint rect, hp, harm, r;
        hf = run_biquad(0, ch, x);
        hf = run_biquad(1, ch, hf);
        rect = (hf < 0) ? -longint'(hf) : longint'(hf);
        hp = rect - last_rect[ch] + ((dc_out[ch] * pole) >>> 24);
        if (hp > bound) hp = bound;
        else if (hp < -bound) hp = -bound;
        last_rect[ch] = rect;
        dc_out[ch] = hp;
        hh = run_biquad(2, ch, int'(hp));
        harm = (longint'(hh) * gain) >>> 24;
        r = longint'(x) + harm;
        if (r > full) r = full;
        else if (r < -full) r = -full;
        return r;
    endfunction

    function automatic logic [63:0] excite_frame(logic [63:0] frame);
        longint full, bound, lo, ro;
        full = (longint'(1) << fs_bits) - 1;
        bound = (2 * full > 64'sd2147483647) ? 64'sd2147483647 : 2 * full;
        lo = excite_channel(0, int'(frame[31:0]), full, bound);
        if (stereo) ro = excite_channel(1, int'(frame[63:32]), full, bound);
        else ro = lo;
        return {ro[31:0], lo[31:0]};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ate_pkg::RegB0B2:    cb0 = longint'(signed'(data));
            ate_pkg::RegB1:      cb1 = longint'(signed'(data));
            ate_pkg::RegA1:      ca1 = longint'(signed'(data));
            ate_pkg::RegA2:      ca2 = longint'(signed'(data));
            ate_pkg::RegDcPole:  pole = longint'(data[24:0]);
            ate_pkg::RegGain:    gain = longint'(data[30:0]);
            ate_pkg::RegFracBit: fs_bits = int'(data[4:0]);
            default:             stereo = data[0];
        endcase
        @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back requests and is dropped only
    // when the sender idles or a phase ends.
    task automatic send_frame(logic [31:0] left, logic [31:0] right);
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_frames.push_back(excite_frame({right, left}));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (exp_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_filter(int b0, int b1, int a1, int a2);
        write_reg(ate_pkg::RegB0B2, b0);
        write_reg(ate_pkg::RegB1, b1);
        write_reg(ate_pkg::RegA1, a1);
        write_reg(ate_pkg::RegA2, a2);
    endtask

    function automatic logic [31:0] pick_sample();
        int full;
        case ($urandom_range(9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2, 3:    return $urandom();
            default: begin
                full = (fs_bits >= 31) ? 32'h7fffffff : (1 << fs_bits) - 1;
                return $urandom_range(2 * full) - full;
            end
        endcase
    endfunction

    task automatic randomize_settings;
        int b0;
        if ($urandom_range(9) < 7) begin
            // A high-pass filter with 24 fractional bits.
            b0 = $urandom_range(16777216, 10000000);
            set_filter(b0, -2 * b0, $urandom_range(32000000, 20000000),
                       -$urandom_range(15000000, 5000000));
        end else begin
            set_filter($urandom(), $urandom(), $urandom(), $urandom());
        end
        case ($urandom_range(3))
            0:       write_reg(ate_pkg::RegDcPole, 0);
            1:       write_reg(ate_pkg::RegDcPole, 32'h1ffffff);
            2:       write_reg(ate_pkg::RegDcPole, 32'h1000000);
            default: write_reg(ate_pkg::RegDcPole, $urandom_range(32'h1ffffff));
        endcase
        case ($urandom_range(3))
            0:       write_reg(ate_pkg::RegGain, 32'h7fffffff);
            1:       write_reg(ate_pkg::RegGain, 0);
            default: write_reg(ate_pkg::RegGain, $urandom_range(32'h7fffffff));
        endcase
        case ($urandom_range(5))
            0:       write_reg(ate_pkg::RegFracBit, $urandom_range(7));
            1:       write_reg(ate_pkg::RegFracBit, 31);
            2:       write_reg(ate_pkg::RegFracBit, 8);
            default: write_reg(ate_pkg::RegFracBit, $urandom_range(31, 8));
        endcase
        write_reg(ate_pkg::RegStereo, $urandom_range(1));
    endtask

    task automatic test_directed;
        // Reset settings: no harmonics, so outputs are the clamped dry samples.
        send_frame(32'h7fffffff, 32'h80000000);
        send_frame(32'h00000000, 32'hffffffff);
        send_frame(32'h80000001, 32'h07ffffff);
        drain();
        set_filter(15000000, -30000000, 30000000, -13500000);
        write_reg(ate_pkg::RegGain, 32'h7fffffff);
        write_reg(ate_pkg::RegFracBit, 31);
        send_frame(32'h7fffffff, 32'h80000000);
        send_frame(32'h80000000, 32'h7fffffff);
        send_frame(32'h7fffffff, 32'h7fffffff);
        send_frame(32'h00000001, 32'hffffffff);
        drain();
        // Largest pole with a tiny full scale; zero fraction bits forces zero.
        write_reg(ate_pkg::RegDcPole, 32'h1ffffff);
        write_reg(ate_pkg::RegFracBit, 8);
        send_frame(32'h000000ff, 32'hffffff01);
        send_frame(32'h55555555, 32'haaaaaaaa);
        drain();
        write_reg(ate_pkg::RegFracBit, 0);
        send_frame(32'h12345678, 32'h87654321);
        drain();
        // Mono mode with full-range coefficients so the accumulator wraps.
        write_reg(ate_pkg::RegStereo, 0);
        write_reg(ate_pkg::RegFracBit, 27);
        write_reg(ate_pkg::RegDcPole, 0);
        set_filter(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_frame(32'h7fffffff, 32'h00000000);
        send_frame(32'h80000000, 32'h7fffffff);
        send_frame(32'h00ff00ff, 32'hff00ff00);
        drain();
        write_reg(ate_pkg::RegStereo, 1);
        send_frame(32'hc0000000, 32'h3fffffff);
        send_frame(32'h40000000, 32'hbfffffff);
        drain();
    endtask

    task automatic test_random(int frames, int s_idle, int r_idle);
        snd_idle = s_idle;
        rcv_idle = r_idle;
        for (int i = 0; i < frames; i++) begin
            if (i % 120 == 0) begin
                drain();
                randomize_settings();
            end
            send_frame(pick_sample(), pick_sample());
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (exp_frames.size() == 0) begin
                $display("%0t: unexpected frame %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = exp_frames.pop_front();
                if (m_axis_tdata[31:0] !== want[31:0]) begin
                    $display("%0t: left_out expected %h actual %h",
                             $time, want[31:0], m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== want[63:32]) begin
                    $display("%0t: right_out expected %h actual %h",
                             $time, want[63:32], m_axis_tdata[63:32]);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("audio_treble_exciter_tb: FAIL");
            $finish;
        end
    end

    initial begin
        cb0 = 0;
        cb1 = 0;
        ca1 = 0;
        ca2 = 0;
        pole = 64'd16777216;
        gain = 0;
        fs_bits = 27;
        stereo = 1'b1;
        foreach (hist[f, c, k]) hist[f][c][k] = 0;
        foreach (dc_out[c]) begin
            dc_out[c] = 0;
            last_rect[c] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(480, 6, 65);
        test_random(480, 65, 6);
        test_random(490, 0, 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0 && exp_frames.size() == 0) begin
            $display("audio_treble_exciter_tb: PASS");
        end else begin
            $display("audio_treble_exciter_tb: FAIL");
        end
        $finish;
    end

endmodule
